// ----- rtl/triangle_face_normal_core_assert.svh -----
// assertion macros for the triangle face normal core
`ifndef TRIANGLE_FACE_NORMAL_CORE_ASSERT_SVH
`define TRIANGLE_FACE_NORMAL_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define TFN_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TFN_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define TFN_ASSERT(label, prop, msg)
`define TFN_ASSERT_NEVER(label, cond, msg)
`endif
`endif

// ----- rtl/tfn_pkg.sv -----
// shared types and constants of the triangle face normal core
`default_nettype none
package tfn_pkg;
    localparam int COORD_WIDTH = 16;
    localparam int SLOT_WIDTH  = 10;
    localparam int LIMIT_WIDTH = 36;
    localparam int NORM_WIDTH  = 16;
    localparam int FRAC_STEPS  = 15;
    localparam int EDGE_WIDTH  = COORD_WIDTH + 1;
    localparam int PROD_WIDTH  = 2 * EDGE_WIDTH;
    localparam int CROSS_WIDTH = PROD_WIDTH + 1;
    localparam int MAG_WIDTH   = PROD_WIDTH;
    localparam int HALF_WIDTH  = MAG_WIDTH / 2;
    localparam int MUL_WIDTH   = HALF_WIDTH + 1;
    localparam int MULP_WIDTH  = 2 * MUL_WIDTH;
    localparam int SUM_WIDTH   = 2 * MAG_WIDTH;
    localparam int LEN_WIDTH   = MAG_WIDTH;

    localparam int DEF_VERTEX_DEPTH = 1024;
    localparam int DEF_FACE_DEPTH   = 1024;

    localparam logic [1:0] KIND_VERTEX = 2'd0;
    localparam logic [1:0] KIND_FACE   = 2'd1;
    localparam logic [1:0] KIND_QUERY  = 2'd2;

    typedef struct packed {
        logic [1:0]                    kind;
        logic [SLOT_WIDTH-1:0]         slot;
        logic signed [COORD_WIDTH-1:0] coord_x;
        logic signed [COORD_WIDTH-1:0] coord_y;
        logic signed [COORD_WIDTH-1:0] coord_z;
        logic [SLOT_WIDTH-1:0]         corner_a;
        logic [SLOT_WIDTH-1:0]         corner_b;
        logic [SLOT_WIDTH-1:0]         corner_c;
    } in_item_t;

    typedef struct packed {
        logic [SLOT_WIDTH-1:0]        face_number;
        logic signed [NORM_WIDTH-1:0] normal_x;
        logic signed [NORM_WIDTH-1:0] normal_y;
        logic signed [NORM_WIDTH-1:0] normal_z;
        logic                         degenerate;
    } out_item_t;
endpackage
`default_nettype wire

// ----- rtl/tfn_ram.sv -----
// generic single-port ram with registered read
`default_nettype none
module tfn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    addr,
    input  wire logic [WIDTH-1:0] wdata,
    output logic      [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;
endmodule
`default_nettype wire

// ----- rtl/tfn_wrap.sv -----
// folds a 10-bit entry number into the depth of a store
`default_nettype none
module tfn_wrap #(
    parameter int DEPTH = tfn_pkg::DEF_VERTEX_DEPTH,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic [tfn_pkg::SLOT_WIDTH-1:0] num,
    output logic      [AW-1:0]                  idx
);
    import tfn_pkg::*;

    generate
        if (DEPTH >= (1 << SLOT_WIDTH))
        begin : g_direct
            assign idx = AW'(num);
        end
        else
        begin : g_fold
            localparam int SH = SLOT_WIDTH + AW;
            localparam int RW = SH + 1;
            localparam logic [RW-1:0] RECIP =
                RW'(((64'd1 << SH) + 64'(DEPTH) - 64'd1) / 64'(DEPTH));
            logic [SLOT_WIDTH+RW-1:0] prod;
            logic [SLOT_WIDTH-1:0]    quo;
            logic [SLOT_WIDTH-1:0]    back;
            logic [SLOT_WIDTH-1:0]    rem;
            // reciprocal multiply, exact for every 10-bit number
            assign prod = {{RW{1'b0}}, num} * {{SLOT_WIDTH{1'b0}}, RECIP};
            assign quo  = prod[SH +: SLOT_WIDTH];
            assign back = quo * SLOT_WIDTH'(DEPTH);
            assign rem  = num - back;
            assign idx  = rem[AW-1:0];
        end
    endgenerate
endmodule
`default_nettype wire

// ----- rtl/tfn_sqrt.sv -----
// bit-serial integer square root, one result bit per cycle
`default_nettype none
module tfn_sqrt (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [tfn_pkg::SUM_WIDTH-1:0] radicand,
    output logic                               done,
    output logic      [tfn_pkg::LEN_WIDTH-1:0] root
);
    import tfn_pkg::*;
    localparam int CNT_W = $clog2(LEN_WIDTH);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(LEN_WIDTH - 1);

    logic [SUM_WIDTH-1:0]   rad_reg;
    logic [LEN_WIDTH-1:0]   rem_reg;
    logic [LEN_WIDTH-1:0]   root_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic                   run_reg;
    logic                   done_reg;
    logic [LEN_WIDTH+1:0]   rem_sh;
    logic [LEN_WIDTH+1:0]   trial;
    logic [LEN_WIDTH+1:0]   diff;
    logic                   fits;

    assign rem_sh = {rem_reg, rad_reg[SUM_WIDTH-1 -: 2]};
    assign trial  = {root_reg, 2'b01};
    assign fits   = rem_sh >= trial;
    assign diff   = rem_sh - trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= run_reg && (cnt_reg == CNT_LAST);
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    run_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (run_reg)
        begin
            rad_reg  <= {rad_reg[SUM_WIDTH-3:0], 2'b00};
            // remainder stays below twice the root, so it fits the narrow register
            rem_reg  <= fits ? diff[LEN_WIDTH-1:0] : rem_sh[LEN_WIDTH-1:0];
            root_reg <= {root_reg[LEN_WIDTH-2:0], fits};
        end
    end

    assign done = done_reg;
    assign root = root_reg;
endmodule
`default_nettype wire

// ----- rtl/tfn_div.sv -----
// three-lane restoring divider giving the q0.15 fraction magnitudes
`default_nettype none
module tfn_div (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    input  wire logic [tfn_pkg::LEN_WIDTH-1:0]       len,
    input  wire logic [2:0][tfn_pkg::MAG_WIDTH-1:0]  mag,
    output logic                                     done,
    output logic      [2:0][tfn_pkg::FRAC_STEPS-1:0] quo
);
    import tfn_pkg::*;
    localparam int CNT_W = $clog2(FRAC_STEPS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(FRAC_STEPS - 1);

    logic [LEN_WIDTH-1:0]        len_reg;
    logic [2:0][LEN_WIDTH-1:0]   r_reg;
    logic [2:0][FRAC_STEPS-1:0]  q_reg;
    logic [2:0]                  sat_reg;
    logic [CNT_W-1:0]            cnt_reg;
    logic                        run_reg;
    logic                        done_reg;
    logic [2:0][LEN_WIDTH-1:0]   r_next;
    logic [2:0]                  bit_next;
    logic [LEN_WIDTH:0]          r_sh;
    logic [LEN_WIDTH:0]          r_diff;

    always_comb
    begin
        r_next   = r_reg;
        bit_next = '0;
        r_sh     = '0;
        r_diff   = '0;
        for (int i = 0; i < 3; i++)
        begin
            r_sh   = {r_reg[i], 1'b0};
            r_diff = r_sh - {1'b0, len_reg};
            bit_next[i] = r_sh >= {1'b0, len_reg};
            r_next[i]   = bit_next[i] ? r_diff[LEN_WIDTH-1:0] : r_sh[LEN_WIDTH-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= run_reg && (cnt_reg == CNT_LAST);
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    run_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            len_reg <= len;
            for (int i = 0; i < 3; i++)
            begin
                r_reg[i]   <= mag[i];
                q_reg[i]   <= '0;
                // a component as long as the whole vector is full scale
                sat_reg[i] <= mag[i] >= len;
            end
        end
        else if (run_reg)
        begin
            r_reg <= r_next;
            for (int i = 0; i < 3; i++)
            begin
                q_reg[i] <= {q_reg[i][FRAC_STEPS-2:0], bit_next[i]};
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            quo[i] = sat_reg[i] ? {FRAC_STEPS{1'b1}} : q_reg[i];
        end
    end

    assign done = done_reg;
endmodule
`default_nettype wire

// ----- rtl/triangle_face_normal_core.sv -----
// top level of the triangle face normal core
`default_nettype none
`include "triangle_face_normal_core_assert.svh"
// Keeps a vertex ram and a face ram and returns the unit normal of a stored face.
// Input: an item is taken at a clock edge where start is high and busy is low.
//   kind vertex writes coordinates, kind face writes three vertex numbers; both
//   finish in the accept cycle, give no result and keep busy low, so writes can
//   be issued every cycle while no query is running. Kind 3 is dropped.
// Query: busy stays high while the query runs; the result transfer follows, with done high
//   for one cycle. The run time is set by the ram reads, one shared 18x18 multiplier for
//   the cross product and the squared length, the bit-serial square root (one bit per
//   cycle, 34 bits) and the three-lane divider (15 fraction bits), skipped for a
//   degenerate face.
// Output: result and done are registered; the receiver cannot stall, so each
//   result must be taken in the cycle it is shown.
// limit_we / limit_wdata write the degenerate length limit; write only while idle.
// Reset clears the sequencer and the limit; the rams are not cleared and every
//   entry must be written before a query reads it.
module triangle_face_normal_core #(
    parameter int VERTEX_DEPTH = tfn_pkg::DEF_VERTEX_DEPTH,
    parameter int FACE_DEPTH   = tfn_pkg::DEF_FACE_DEPTH
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    input  wire tfn_pkg::in_item_t               item,
    output logic                                 busy,
    output logic                                 done,
    output tfn_pkg::out_item_t                   result,
    input  wire logic                            limit_we,
    input  wire logic [tfn_pkg::LIMIT_WIDTH-1:0] limit_wdata
);
    import tfn_pkg::*;

    localparam int VAW = (VERTEX_DEPTH > 1) ? $clog2(VERTEX_DEPTH) : 1;
    localparam int FAW = (FACE_DEPTH > 1) ? $clog2(FACE_DEPTH) : 1;
    localparam int VW  = 3 * COORD_WIDTH;
    localparam int FW  = 3 * VAW;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_FACE  = 4'd1;
    localparam logic [3:0] S_VA    = 4'd2;
    localparam logic [3:0] S_VB    = 4'd3;
    localparam logic [3:0] S_VC    = 4'd4;
    localparam logic [3:0] S_EDGE  = 4'd5;
    localparam logic [3:0] S_CROSS = 4'd6;
    localparam logic [3:0] S_MAG   = 4'd7;
    localparam logic [3:0] S_SQ    = 4'd8;
    localparam logic [3:0] S_RGO   = 4'd9;
    localparam logic [3:0] S_SQRT  = 4'd10;
    localparam logic [3:0] S_CHECK = 4'd11;
    localparam logic [3:0] S_DIV   = 4'd12;

    localparam logic [3:0] CROSS_LAST = 4'd6;
    localparam logic [3:0] SQ_LAST    = 4'd9;

    localparam logic [1:0] OP_SET   = 2'd0;
    localparam logic [1:0] OP_SUB   = 2'd1;
    localparam logic [1:0] PART_LO  = 2'd0;
    localparam logic [1:0] PART_MID = 2'd1;
    localparam logic [1:0] PART_HI  = 2'd2;

    logic [3:0]                   state_reg, state_next;
    logic [3:0]                   step_reg;
    logic                         acc;
    logic [LIMIT_WIDTH-1:0]       limit_reg;

    logic [VAW-1:0]               vslot_idx, ca_idx, cb_idx, cc_idx;
    logic [FAW-1:0]               fslot_idx;
    logic [VAW-1:0]               vert_addr;
    logic [FW-1:0]                face_rd;
    logic [VW-1:0]                vert_rd;
    logic [VAW-1:0]               corner_b_reg, corner_c_reg;
    logic [SLOT_WIDTH-1:0]        face_num_reg;
    logic [VW-1:0]                p0_reg, p1_reg, p2_reg;

    logic signed [EDGE_WIDTH-1:0]  e1_reg [3];
    logic signed [EDGE_WIDTH-1:0]  e2_reg [3];
    logic signed [CROSS_WIDTH-1:0] cross_reg [3];
    logic [2:0][MAG_WIDTH-1:0]     mag_reg;
    logic [SUM_WIDTH-1:0]          sum_reg;
    logic [LEN_WIDTH-1:0]          len_reg;

    logic signed [MUL_WIDTH-1:0]   mul_a, mul_b;
    logic signed [MULP_WIDTH-1:0]  prod_reg;
    logic                          issue;
    logic                          prod_vld_reg;
    logic [1:0]                    tag_idx, tag_idx_reg;
    logic [1:0]                    tag_op, tag_op_reg;
    logic [1:0]                    sq_j;
    logic signed [CROSS_WIDTH-1:0] prod_c;
    logic [SUM_WIDTH-1:0]          sq_base, sq_addend;

    logic                          sqrt_start, sqrt_done;
    logic [LEN_WIDTH-1:0]          sqrt_root;
    logic                          div_start, div_done;
    logic [2:0][FRAC_STEPS-1:0]    div_quo;
    logic                          degen;

    out_item_t                     result_reg;
    logic                          done_reg;

    function automatic logic signed [COORD_WIDTH-1:0] coord(input logic [VW-1:0] p,
                                                            input int k);
        return p[(2 - k) * COORD_WIDTH +: COORD_WIDTH];
    endfunction

    function automatic logic [NORM_WIDTH-1:0] apply_sign(input logic [FRAC_STEPS-1:0] q,
                                                         input logic neg);
        logic [NORM_WIDTH-1:0] n;
        n = {1'b0, q};
        return neg ? (~n + 1'b1) : n;
    endfunction

    assign acc  = start && !busy;
    assign busy = state_reg != S_IDLE;

    tfn_wrap #(.DEPTH(VERTEX_DEPTH), .AW(VAW)) u_wrap_vslot (.num(item.slot), .idx(vslot_idx));
    tfn_wrap #(.DEPTH(FACE_DEPTH), .AW(FAW)) u_wrap_fslot (.num(item.slot), .idx(fslot_idx));
    tfn_wrap #(.DEPTH(VERTEX_DEPTH), .AW(VAW)) u_wrap_a (.num(item.corner_a), .idx(ca_idx));
    tfn_wrap #(.DEPTH(VERTEX_DEPTH), .AW(VAW)) u_wrap_b (.num(item.corner_b), .idx(cb_idx));
    tfn_wrap #(.DEPTH(VERTEX_DEPTH), .AW(VAW)) u_wrap_c (.num(item.corner_c), .idx(cc_idx));

    tfn_ram #(.WIDTH(FW), .DEPTH(FACE_DEPTH), .AW(FAW)) u_face_ram (
        .clk   (clk),
        .we    (acc && (item.kind == KIND_FACE)),
        .addr  (fslot_idx),
        .wdata ({ca_idx, cb_idx, cc_idx}),
        .rdata (face_rd)
    );

    // corner a goes straight from the face read, b and c wait in registers
    always_comb
    begin
        case (state_reg)
            S_FACE:  vert_addr = face_rd[FW-1 -: VAW];
            S_VA:    vert_addr = corner_b_reg;
            S_VB:    vert_addr = corner_c_reg;
            default: vert_addr = vslot_idx;
        endcase
    end

    tfn_ram #(.WIDTH(VW), .DEPTH(VERTEX_DEPTH), .AW(VAW)) u_vert_ram (
        .clk   (clk),
        .we    (acc && (item.kind == KIND_VERTEX)),
        .addr  (vert_addr),
        .wdata ({item.coord_x, item.coord_y, item.coord_z}),
        .rdata (vert_rd)
    );

    // shared multiplier operand select
    always_comb
    begin
        mul_a   = '0;
        mul_b   = '0;
        issue   = 1'b0;
        tag_idx = '0;
        tag_op  = OP_SET;
        sq_j    = '0;
        case (state_reg)
            S_CROSS:
            begin
                issue = 1'b1;
                case (step_reg)
                    4'd0:
                    begin
                        mul_a = MUL_WIDTH'(e1_reg[1]); mul_b = MUL_WIDTH'(e2_reg[2]);
                        tag_idx = 2'd0; tag_op = OP_SET;
                    end
                    4'd1:
                    begin
                        mul_a = MUL_WIDTH'(e1_reg[2]); mul_b = MUL_WIDTH'(e2_reg[1]);
                        tag_idx = 2'd0; tag_op = OP_SUB;
                    end
                    4'd2:
                    begin
                        mul_a = MUL_WIDTH'(e1_reg[2]); mul_b = MUL_WIDTH'(e2_reg[0]);
                        tag_idx = 2'd1; tag_op = OP_SET;
                    end
                    4'd3:
                    begin
                        mul_a = MUL_WIDTH'(e1_reg[0]); mul_b = MUL_WIDTH'(e2_reg[2]);
                        tag_idx = 2'd1; tag_op = OP_SUB;
                    end
                    4'd4:
                    begin
                        mul_a = MUL_WIDTH'(e1_reg[0]); mul_b = MUL_WIDTH'(e2_reg[1]);
                        tag_idx = 2'd2; tag_op = OP_SET;
                    end
                    4'd5:
                    begin
                        mul_a = MUL_WIDTH'(e1_reg[1]); mul_b = MUL_WIDTH'(e2_reg[0]);
                        tag_idx = 2'd2; tag_op = OP_SUB;
                    end
                    default: issue = 1'b0;
                endcase
            end
            S_SQ:
            begin
                issue = 1'b1;
                case (step_reg)
                    4'd0: begin sq_j = 2'd0; tag_op = PART_LO; end
                    4'd1: begin sq_j = 2'd0; tag_op = PART_MID; end
                    4'd2: begin sq_j = 2'd0; tag_op = PART_HI; end
                    4'd3: begin sq_j = 2'd1; tag_op = PART_LO; end
                    4'd4: begin sq_j = 2'd1; tag_op = PART_MID; end
                    4'd5: begin sq_j = 2'd1; tag_op = PART_HI; end
                    4'd6: begin sq_j = 2'd2; tag_op = PART_LO; end
                    4'd7: begin sq_j = 2'd2; tag_op = PART_MID; end
                    4'd8: begin sq_j = 2'd2; tag_op = PART_HI; end
                    default: issue = 1'b0;
                endcase
                // square split into halves: lo*lo, lo*hi (doubled by the shift), hi*hi
                mul_a = (tag_op == PART_HI) ? $signed({1'b0, mag_reg[sq_j][MAG_WIDTH-1:HALF_WIDTH]})
                                            : $signed({1'b0, mag_reg[sq_j][HALF_WIDTH-1:0]});
                mul_b = (tag_op == PART_LO) ? $signed({1'b0, mag_reg[sq_j][HALF_WIDTH-1:0]})
                                            : $signed({1'b0, mag_reg[sq_j][MAG_WIDTH-1:HALF_WIDTH]});
                tag_idx = sq_j;
            end
            default: issue = 1'b0;
        endcase
    end

    assign prod_c  = CROSS_WIDTH'(prod_reg);
    assign sq_base = SUM_WIDTH'($unsigned(prod_reg));

    always_comb
    begin
        case (tag_op_reg)
            PART_LO:  sq_addend = sq_base;
            PART_MID: sq_addend = sq_base << (HALF_WIDTH + 1);
            PART_HI:  sq_addend = sq_base << (2 * HALF_WIDTH);
            default:  sq_addend = '0;
        endcase
    end

    assign degen = LIMIT_WIDTH'(len_reg) <= limit_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (acc && (item.kind == KIND_QUERY)) state_next = S_FACE;
            S_FACE:  state_next = S_VA;
            S_VA:    state_next = S_VB;
            S_VB:    state_next = S_VC;
            S_VC:    state_next = S_EDGE;
            S_EDGE:  state_next = S_CROSS;
            S_CROSS: if (step_reg == CROSS_LAST) state_next = S_MAG;
            S_MAG:   state_next = S_SQ;
            S_SQ:    if (step_reg == SQ_LAST) state_next = S_RGO;
            S_RGO:   state_next = S_SQRT;
            S_SQRT:  if (sqrt_done) state_next = S_CHECK;
            S_CHECK: state_next = degen ? S_IDLE : S_DIV;
            S_DIV:   if (div_done) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    assign sqrt_start = state_reg == S_RGO;
    assign div_start  = (state_reg == S_CHECK) && !degen;

    tfn_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (sum_reg),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    tfn_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .len   (len_reg),
        .mag   (mag_reg),
        .done  (div_done),
        .quo   (div_quo)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            step_reg     <= '0;
            prod_vld_reg <= 1'b0;
            done_reg     <= 1'b0;
            limit_reg    <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            step_reg     <= (state_next != state_reg) ? 4'd0 : step_reg + 4'd1;
            prod_vld_reg <= issue;
            done_reg     <= ((state_reg == S_CHECK) && degen)
                            || ((state_reg == S_DIV) && div_done);
            if (limit_we)
            begin
                limit_reg <= limit_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg    <= mul_a * mul_b;
        tag_idx_reg <= tag_idx;
        tag_op_reg  <= tag_op;
        case (state_reg)
            S_IDLE:
            begin
                if (acc)
                begin
                    face_num_reg <= item.slot;
                end
            end
            S_FACE:
            begin
                corner_b_reg <= face_rd[VAW +: VAW];
                corner_c_reg <= face_rd[VAW-1:0];
            end
            S_VA: p0_reg <= vert_rd;
            S_VB: p1_reg <= vert_rd;
            S_VC: p2_reg <= vert_rd;
            S_EDGE:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    e1_reg[k] <= EDGE_WIDTH'(coord(p1_reg, k)) - EDGE_WIDTH'(coord(p0_reg, k));
                    e2_reg[k] <= EDGE_WIDTH'(coord(p2_reg, k)) - EDGE_WIDTH'(coord(p0_reg, k));
                end
            end
            S_CROSS:
            begin
                if (prod_vld_reg)
                begin
                    cross_reg[tag_idx_reg] <= (tag_op_reg == OP_SET) ? prod_c
                                              : cross_reg[tag_idx_reg] - prod_c;
                end
            end
            S_MAG:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    mag_reg[k] <= cross_reg[k][CROSS_WIDTH-1]
                                  ? MAG_WIDTH'(-cross_reg[k]) : MAG_WIDTH'(cross_reg[k]);
                end
                sum_reg <= '0;
            end
            S_SQ:
            begin
                if (prod_vld_reg)
                begin
                    sum_reg <= sum_reg + sq_addend;
                end
            end
            S_SQRT:
            begin
                if (sqrt_done)
                begin
                    len_reg <= sqrt_root;
                end
            end
            S_CHECK:
            begin
                if (degen)
                begin
                    result_reg.face_number <= face_num_reg;
                    result_reg.normal_x    <= '0;
                    result_reg.normal_y    <= '0;
                    result_reg.normal_z    <= '0;
                    result_reg.degenerate  <= 1'b1;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    result_reg.face_number <= face_num_reg;
                    result_reg.normal_x    <= apply_sign(div_quo[0], cross_reg[0][CROSS_WIDTH-1]);
                    result_reg.normal_y    <= apply_sign(div_quo[1], cross_reg[1][CROSS_WIDTH-1]);
                    result_reg.normal_z    <= apply_sign(div_quo[2], cross_reg[2][CROSS_WIDTH-1]);
                    result_reg.degenerate  <= 1'b0;
                end
            end
            default: ;
        endcase
    end

    assign done   = done_reg;
    assign result = result_reg;

    `TFN_ASSERT(a_done_idle, done |-> !busy, "result shown while a query is still running")
    `TFN_ASSERT(a_query_busy, (start && !busy && (item.kind == KIND_QUERY)) |=> busy, "accepted query did not start the sequencer")
    `TFN_ASSERT(a_done_after_work, done |-> $past(busy), "result transfer without a running query")
    `TFN_ASSERT(a_degen_zero, (done && result.degenerate) |-> ((result.normal_x == 0) && (result.normal_y == 0) && (result.normal_z == 0)), "degenerate face with a non-zero normal")
    `TFN_ASSERT_NEVER(a_no_full_neg, done && !result.degenerate && (result.normal_x == 16'sh8000), "normal x beyond saturation")
endmodule
`default_nettype wire

// ----- verif/tb_top.sv -----
// self-checking testbench for the triangle face normal core
`timescale 1ns / 1ps
module tb_top;
    import tfn_pkg::*;

    localparam logic [1:0] KIND_IGNORED = 2'd3;

    logic                   clk;
    logic                   rst_n;
    logic                   start;
    in_item_t               item;
    logic                   busy;
    logic                   done;
    out_item_t              result;
    logic                   limit_we;
    logic [LIMIT_WIDTH-1:0] limit_wdata;

    triangle_face_normal_core uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .item       (item),
        .busy       (busy),
        .done       (done),
        .result     (result),
        .limit_we   (limit_we),
        .limit_wdata(limit_wdata)
    );

    // predictor state
    logic signed [COORD_WIDTH-1:0] vert_mem [1024][3];
    logic [SLOT_WIDTH-1:0]         face_mem [1024][3];
    logic [LIMIT_WIDTH-1:0]        limit_model;

    // generator view of which entries hold data
    bit vert_ok [1024];
    int ok_faces[$];

    in_item_t  pending_items[$];
    out_item_t normals_due[$];
    int        errors;
    int        idle_pct;
    logic      took;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic logic [63:0] mag64(longint v);
        return (v < 0) ? 64'(-v) : 64'(v);
    endfunction

    function automatic out_item_t face_normal(logic [SLOT_WIDTH-1:0] f);
        out_item_t   r;
        longint      p [3][3];
        longint      e1[3];
        longint      e2[3];
        longint      c [3];
        logic [71:0] sum;
        logic [71:0] m;
        logic [71:0] root;
        logic [71:0] t;
        logic [63:0] a;
        logic [63:0] rem;
        logic [63:0] q;
        for (int i = 0; i < 3; i++)
            for (int k = 0; k < 3; k++)
                p[i][k] = vert_mem[face_mem[f][i]][k];
        for (int k = 0; k < 3; k++)
        begin
            e1[k] = p[1][k] - p[0][k];
            e2[k] = p[2][k] - p[0][k];
        end
        c[0] = e1[1] * e2[2] - e1[2] * e2[1];
        c[1] = e1[2] * e2[0] - e1[0] * e2[2];
        c[2] = e1[0] * e2[1] - e1[1] * e2[0];
        sum = '0;
        for (int k = 0; k < 3; k++)
        begin
            m = 72'(mag64(c[k]));
            sum += m * m;
        end
        // trial root kept below 2^36 so its square fits 72 bits
        root = '0;
        for (int b = 35; b >= 0; b--)
        begin
            t = root | (72'd1 << b);
            if (t * t <= sum)
                root = t;
        end
        r.face_number = f;
        if (root <= 72'(limit_model))
        begin
            r.normal_x   = '0;
            r.normal_y   = '0;
            r.normal_z   = '0;
            r.degenerate = 1'b1;
            return r;
        end
        for (int k = 0; k < 3; k++)
        begin
            a = mag64(c[k]);
            q = '0;
            if (a >= root[63:0])
                q = 64'd32767;
            else
            begin
                rem = a;
                for (int i = 0; i < FRAC_STEPS; i++)
                begin
                    rem = rem << 1;
                    q   = q << 1;
                    if (rem >= root[63:0])
                    begin
                        rem = rem - root[63:0];
                        q[0] = 1'b1;
                    end
                end
                if (q > 64'd32767)
                    q = 64'd32767;
            end
            if (c[k] < 0)
                q = -q;
            case (k)
                0: r.normal_x = q[15:0];
                1: r.normal_y = q[15:0];
                default: r.normal_z = q[15:0];
            endcase
        end
        r.degenerate = 1'b0;
        return r;
    endfunction

    function automatic void apply_item(in_item_t it);
        case (it.kind)
            KIND_VERTEX:
            begin
                vert_mem[it.slot][0] = it.coord_x;
                vert_mem[it.slot][1] = it.coord_y;
                vert_mem[it.slot][2] = it.coord_z;
            end
            KIND_FACE:
            begin
                face_mem[it.slot][0] = it.corner_a;
                face_mem[it.slot][1] = it.corner_b;
                face_mem[it.slot][2] = it.corner_c;
            end
            KIND_QUERY: normals_due = {normals_due, face_normal(it.slot)};
            default: ;
        endcase
    endfunction

    function automatic void queue_item(in_item_t it);
        pending_items = {pending_items, it};
    endfunction

    // driver: a held item stays up until its transfer
    always @(negedge clk)
    begin
        if (rst_n && (!start || took))
        begin
            if (pending_items.size() > 0 && $urandom_range(99) >= idle_pct)
            begin
                start <= 1'b1;
                item  <= pending_items.pop_front();
            end
            else
                start <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        took <= rst_n && start && !busy;
        if (rst_n && start && !busy)
            apply_item(item);
        if (rst_n && done)
        begin
            if (normals_due.size() == 0)
            begin
                $display("%0t: result with none expected: actual %p", $time, result);
                errors++;
            end
            else
            begin
                out_item_t exp_r;
                exp_r = normals_due.pop_front();
                if (result.face_number !== exp_r.face_number
                    || result.normal_x !== exp_r.normal_x
                    || result.normal_y !== exp_r.normal_y
                    || result.normal_z !== exp_r.normal_z
                    || result.degenerate !== exp_r.degenerate)
                begin
                    $display("%0t: mismatch face %0d: expected n=(%0d,%0d,%0d) deg=%0b",
                             $time, exp_r.face_number, exp_r.normal_x, exp_r.normal_y,
                             exp_r.normal_z, exp_r.degenerate);
                    $display("%0t:   actual face %0d n=(%0d,%0d,%0d) deg=%0b",
                             $time, result.face_number, result.normal_x, result.normal_y,
                             result.normal_z, result.degenerate);
                    errors++;
                end
            end
        end
    end

    function automatic in_item_t noise_item(logic [1:0] k);
        in_item_t    it;
        logic [95:0] raw;
        raw = {$urandom, $urandom, $urandom};
        it = raw[$bits(in_item_t)-1:0];
        it.kind = k;
        return it;
    endfunction

    task automatic add_vertex(int s, int x, int y, int z);
        in_item_t it;
        it = noise_item(KIND_VERTEX);
        it.slot    = SLOT_WIDTH'(s);
        it.coord_x = COORD_WIDTH'(x);
        it.coord_y = COORD_WIDTH'(y);
        it.coord_z = COORD_WIDTH'(z);
        vert_ok[s] = 1'b1;
        queue_item(it);
    endtask

    task automatic add_face(int s, int a, int b, int c);
        in_item_t it;
        it = noise_item(KIND_FACE);
        it.slot     = SLOT_WIDTH'(s);
        it.corner_a = SLOT_WIDTH'(a);
        it.corner_b = SLOT_WIDTH'(b);
        it.corner_c = SLOT_WIDTH'(c);
        if (!(s inside {ok_faces}))
            ok_faces = {ok_faces, s};
        queue_item(it);
    endtask

    task automatic add_query(int s);
        in_item_t it;
        it = noise_item(KIND_QUERY);
        it.slot = SLOT_WIDTH'(s);
        queue_item(it);
    endtask

    function automatic int rand_coord();
        case ($urandom_range(2))
            0: return $signed(16'($urandom));
            1: return $signed(16'($urandom_range(0, 511))) - 256;
            default: return $signed(16'($urandom_range(0, 8191))) - 4096;
        endcase
    endfunction

    function automatic int rand_vertex();
        int v;
        do v = $urandom_range(1023); while (!vert_ok[v]);
        return v;
    endfunction

    // wait until the block has nothing left in flight
    task automatic drain();
        wait (pending_items.size() == 0 && normals_due.size() == 0);
        @(negedge clk);
        wait (!start && !busy);
        repeat (100) @(negedge clk);
    endtask

    task automatic set_limit(logic [LIMIT_WIDTH-1:0] v);
        drain();
        limit_we    <= 1'b1;
        limit_wdata <= v;
        limit_model  = v;
        @(negedge clk);
        limit_we    <= 1'b0;
    endtask

    // three fresh vertices, a face over them and its query
    task automatic triangle();
        int v[3];
        int f;
        for (int i = 0; i < 3; i++)
            v[i] = $urandom_range(1023);
        f = $urandom_range(1023);
        case ($urandom_range(9))
            0: add_vertex(v[0], 7, -3, 11);  // fixed corner coordinates
            default: add_vertex(v[0], rand_coord(), rand_coord(), rand_coord());
        endcase
        add_vertex(v[1], rand_coord(), rand_coord(), rand_coord());
        if ($urandom_range(9) == 0)
            add_vertex(v[2], 0, 0, 0);
        else
            add_vertex(v[2], rand_coord(), rand_coord(), rand_coord());
        add_face(f, v[0], v[1], v[2]);
        add_query(f);
    endtask

    initial
    begin
        logic [LIMIT_WIDTH-1:0] phase_limit [4];
        int                     phase_idle  [4];
        rst_n       = 1'b0;
        start       = 1'b0;
        item        = '0;
        limit_we    = 1'b0;
        limit_wdata = '0;
        limit_model = '0;
        took        = 1'b0;
        errors      = 0;
        idle_pct    = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        set_limit('0);
        // axis aligned normals: full scale, both signs
        add_vertex(0, 0, 0, 0);
        add_vertex(1, 256, 0, 0);
        add_vertex(2, 0, 256, 0);
        add_face(0, 0, 1, 2);
        add_query(0);
        add_face(1, 0, 2, 1);
        add_query(1);
        // coordinate extremes
        add_vertex(1021, -32768, -32768, -32768);
        add_vertex(1022, 32767, 32767, -32768);
        add_vertex(1023, 32767, -32768, 32767);
        add_face(1023, 1021, 1022, 1023);
        add_query(1023);
        // coincident and collinear corners
        add_face(5, 0, 0, 0);
        add_query(5);
        add_vertex(3, 512, 0, 0);
        add_face(6, 0, 1, 3);
        add_query(6);
        queue_item(noise_item(KIND_IGNORED));
        add_vertex(4, 1, 2, 3);
        add_face(7, 4, 1, 2);
        add_query(7);
        set_limit({LIMIT_WIDTH{1'b1}});
        add_query(0);
        add_query(1023);

        phase_idle  = '{0, 61, 0, 8};
        phase_limit = '{36'd0, 36'd300000, 36'($urandom_range(1, 1 << 20)), 36'd1 << 30};
        for (int ph = 0; ph < 4; ph++)
        begin
            set_limit(phase_limit[ph]);
            idle_pct = phase_idle[ph];
            for (int n = 0; n < 36; n++)
            begin
                if ($urandom_range(4) != 0)
                    triangle();
                else
                    case ($urandom_range(3))
                        0: add_query(ok_faces[$urandom_range(ok_faces.size() - 1)]);
                        1: queue_item(noise_item(KIND_IGNORED));
                        2: add_vertex(rand_vertex(), rand_coord(), rand_coord(),
                                      rand_coord());
                        default: add_face($urandom_range(1023), rand_vertex(),
                                          rand_vertex(), rand_vertex());
                    endcase
                if (n == 18)
                    drain();
            end
        end

        drain();
        if (errors == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("tb_top: errors");
        $finish;
    end
endmodule
